// File: rtl/puf_pkg.sv
// Shared types and constants for the PNG scanline unfilter block.
// No dependencies; puf_csr, puf_predict and the top level import this package.
package puf_pkg;

   // Default sizes handed to the top-level parameters
   localparam int MAX_ROW_BYTES_DEF   = 4096;
   localparam int MAX_PIXEL_BYTES_DEF = 8;

   // Left and upper-left history depth and index width
   localparam int HIST_DEPTH = 8;
   localparam int HIST_IDX_W = 3;

   // Register widths and map
   localparam int BPP_W       = 4;
   localparam int ROW_BYTES_W = 13;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_IDX_W   = 1;

   localparam logic [CSR_IDX_W-1:0] REG_BPP       = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_BYTES = 1'd1;

   // Filter types of a scanline
   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4
   } filter_type;

   // Control of one data byte on its way into the predictor
   typedef struct packed {
      logic                  has_left;
      logic                  first_row;
      filter_type            filter;
      logic [HIST_IDX_W-1:0] stride_idx;
      logic                  last;
   } pred_ctl_type;

endpackage

// File: rtl/puf_stream_if.sv
// Valid/ready stream interfaces for the unfilter input and result channels.
// No dependencies.
interface puf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       image_start;

   modport source (output valid, output in_byte, output image_start, input ready);
   modport sink   (input valid, input in_byte, input image_start, output ready);
endinterface

interface puf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       row_last;

   modport source (output valid, output out_byte, output row_last, input ready);
   modport sink   (input valid, input out_byte, input row_last, output ready);
endinterface

// File: rtl/puf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module puf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/puf_csr.sv
// APB-style register file: pixel stride and row length.
// Depends on puf_pkg.
module puf_csr
   import puf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready,
   output logic [BPP_W-1:0]       bytes_per_pixel,
   output logic [ROW_BYTES_W-1:0] row_bytes
);

   logic [BPP_W-1:0]       bpp_ff;
   logic [ROW_BYTES_W-1:0] row_bytes_ff;
   logic [CSR_IDX_W-1:0]   reg_idx;
   logic                   wr_xfer;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_xfer = psel && penable && pwrite && pready;

   // Write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_W'(1);
         row_bytes_ff <= ROW_BYTES_W'(1);
      end else if (wr_xfer) begin
         case (reg_idx)
            REG_BPP:       bpp_ff       <= pwdata[BPP_W-1:0];
            REG_ROW_BYTES: row_bytes_ff <= pwdata[ROW_BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_BPP:       prdata = CSR_DATA_W'(bpp_ff);
         REG_ROW_BYTES: prdata = CSR_DATA_W'(row_bytes_ff);
         default:       prdata = '0;
      endcase
   end

   assign bytes_per_pixel = bpp_ff;
   assign row_bytes       = row_bytes_ff;

endmodule

// File: rtl/puf_predict.sv
// Prediction and reconstruction of one data byte, with left/upper-left history.
// Depends on puf_pkg.
module puf_predict
   import puf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  pred_ctl_type ctl,
   input  logic [7:0]   filt_byte,
   input  logic [7:0]   above_byte,
   output logic [7:0]   val
);

   logic [7:0] left_ff   [HIST_DEPTH];
   logic [7:0] upleft_ff [HIST_DEPTH];

   logic [7:0]        a;
   logic [7:0]        b;
   logic [7:0]        c;
   logic [7:0]        pred;
   logic [8:0]        ab_sum;
   logic signed [9:0] d_bc;
   logic signed [9:0] d_ac;
   logic signed [9:0] d_abc;
   logic [9:0]        pa;
   logic [9:0]        pb;
   logic [9:0]        pc;

   // Neighbors; the row above the first row reads as zero
   assign a = ctl.has_left ? left_ff[ctl.stride_idx] : 8'd0;
   assign b = ctl.first_row ? 8'd0 : above_byte;
   assign c = (ctl.has_left && !ctl.first_row) ? upleft_ff[ctl.stride_idx] : 8'd0;

   // Paeth distances
   assign ab_sum = {1'b0, a} + {1'b0, b};
   assign d_bc   = $signed({2'b00, b}) - $signed({2'b00, c});
   assign d_ac   = $signed({2'b00, a}) - $signed({2'b00, c});
   assign d_abc  = $signed({1'b0, ab_sum}) - $signed({1'b0, c, 1'b0});
   assign pa     = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
   assign pb     = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
   assign pc     = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

   // Select the prediction
   always_comb begin
      case (ctl.filter)
         FILT_SUB:   pred = a;
         FILT_UP:    pred = b;
         FILT_AVG:   pred = ab_sum[8:1];
         FILT_PAETH: begin
            if (pa <= pb && pa <= pc) begin
               pred = a;
            end else if (pb <= pc) begin
               pred = b;
            end else begin
               pred = c;
            end
         end
         default:    pred = 8'd0;
      endcase
   end

   assign val = pred + filt_byte;

   // Shift history on each transfer out of the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < HIST_DEPTH; k++) begin
            left_ff[k]   <= 8'd0;
            upleft_ff[k] <= 8'd0;
         end
      end else if (advance) begin
         for (int k = HIST_DEPTH - 1; k > 0; k--) begin
            left_ff[k]   <= left_ff[k-1];
            upleft_ff[k] <= upleft_ff[k-1];
         end
         left_ff[0]   <= val;
         upleft_ff[0] <= b;
      end
   end

endmodule

// File: rtl/png_scanline_unfilter.sv
// PNG scanline filter reconstruction, top level: row sequencing and prior-row RAM.
// Depends on puf_pkg, puf_stream_if, puf_ram, puf_csr and puf_predict.
//
//   channel   direction   handshake        payload
//   req_if    in          valid / ready    in_byte[7:0], image_start
//   rsp_if    out         valid / ready    out_byte[7:0], row_last
//   csr       in          psel / penable   paddr[2:0], pwdata / prdata[31:0]
//
// One byte per cycle, filter bytes included, while the input does not stall. A data
// byte passes the predictor stage, which reads the prior-row RAM, then the output
// register. The input stalls while the predictor stage holds a byte and the output
// register holds a result not yet transferred, or while the held byte has yet to
// write the prior-row entry the next data byte reads; otherwise the filter byte
// between rows gives that write time to land. Synchronous reset clears the row state
// and history, not the prior-row RAM. A stalled result holds while a new byte enters.
module png_scanline_unfilter
   import puf_pkg::*;
#(
   parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
   parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   puf_req_if.sink               req_if,
   puf_rsp_if.source             rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int POS_W = $clog2(MAX_ROW_BYTES);
   localparam int CMP_W = (POS_W + 1 > ROW_BYTES_W) ? POS_W + 1 : ROW_BYTES_W;

   logic [BPP_W-1:0]       bytes_per_pixel;
   logic [ROW_BYTES_W-1:0] row_bytes;

   // Row state
   logic             expect_filter_ff;
   logic [POS_W-1:0] count_ff;
   filter_type       filter_ff;
   logic             first_row_ff;

   // Predictor stage
   logic             s1_valid_ff;
   logic [POS_W-1:0] s1_pos_ff;
   logic [7:0]       s1_byte_ff;
   pred_ctl_type     s1_ctl_ff;
   pred_ctl_type     s1_ctl_in;

   // Output register
   logic       out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   logic             accept;
   logic             is_filter;
   logic             is_data;
   logic             s1_adv;
   logic             hazard;
   logic [BPP_W-1:0] stride_eff;
   logic [CMP_W-1:0] len_raw;
   logic [CMP_W-1:0] len_eff;
   logic             has_left;
   logic             last;
   filter_type       filter_dec;
   logic [7:0]       above_byte;
   logic [7:0]       val;

   puf_csr u_csr (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .bytes_per_pixel (bytes_per_pixel),
      .row_bytes       (row_bytes)
   );

   // Clamp stride and row length into range
   always_comb begin
      if (bytes_per_pixel == '0) begin
         stride_eff = BPP_W'(1);
      end else if (bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
         stride_eff = BPP_W'(MAX_PIXEL_BYTES);
      end else begin
         stride_eff = bytes_per_pixel;
      end
      len_raw = CMP_W'(row_bytes);
      if (len_raw == '0) begin
         len_eff = CMP_W'(1);
      end else if (len_raw > CMP_W'(MAX_ROW_BYTES)) begin
         len_eff = CMP_W'(MAX_ROW_BYTES);
      end else begin
         len_eff = len_raw;
      end
   end

   // Decode the incoming byte against the row state
   assign is_filter = req_if.image_start || expect_filter_ff;
   assign is_data   = !is_filter;
   assign has_left  = CMP_W'(count_ff) >= CMP_W'(stride_eff);
   assign last      = (CMP_W'(count_ff) + CMP_W'(1)) >= len_eff;

   always_comb begin
      if (req_if.in_byte inside {[8'd0:8'd4]}) begin
         filter_dec = filter_type'(req_if.in_byte[2:0]);
      end else begin
         filter_dec = FILT_NONE;
      end
   end

   // Handshake: hold the input while the stage ahead is blocked or still owes this entry
   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign hazard = s1_valid_ff && !expect_filter_ff && (s1_pos_ff == count_ff);
   assign req_if.ready = !s1_valid_ff || (s1_adv && !hazard);
   assign accept = req_if.valid && req_if.ready;

   // Advance the row state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         expect_filter_ff <= 1'b1;
         count_ff         <= '0;
         filter_ff        <= FILT_NONE;
         first_row_ff     <= 1'b1;
      end else if (accept) begin
         if (is_filter) begin
            expect_filter_ff <= 1'b0;
            count_ff         <= '0;
            filter_ff        <= filter_dec;
            if (req_if.image_start) begin
               first_row_ff <= 1'b1;
            end
         end else if (last) begin
            expect_filter_ff <= 1'b1;
            count_ff         <= '0;
            first_row_ff     <= 1'b0;
         end else begin
            count_ff <= count_ff + POS_W'(1);
         end
      end
   end

   // Load the predictor stage with a data byte
   always_comb begin
      s1_ctl_in.has_left   = has_left;
      s1_ctl_in.first_row  = first_row_ff;
      s1_ctl_in.filter     = filter_ff;
      s1_ctl_in.stride_idx = HIST_IDX_W'(stride_eff - BPP_W'(1));
      s1_ctl_in.last       = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept && is_data) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_data) begin
         s1_pos_ff  <= count_ff;
         s1_byte_ff <= req_if.in_byte;
         s1_ctl_ff  <= s1_ctl_in;
      end
   end

   // Prior row: read on transfer in, write the reconstructed byte on advance
   puf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_prior_row (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_pos_ff),
      .wr_data (val),
      .rd_en   (accept && is_data),
      .rd_addr (count_ff),
      .rd_data (above_byte)
   );

   puf_predict u_predict (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_adv),
      .ctl        (s1_ctl_ff),
      .filt_byte  (s1_byte_ff),
      .above_byte (above_byte),
      .val        (val)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_byte_ff <= val;
         out_last_ff <= s1_ctl_ff.last;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.out_byte = out_byte_ff;
   assign rsp_if.row_last = out_last_ff;

endmodule
